// File: rtl/mdpf_pkg.sv
`default_nettype none

package mdpf_pkg;

   localparam int MAX_PAIRS     = 16;
   localparam int POSITION_BITS = 16;
   localparam int COUNT_BITS    = $clog2(MAX_PAIRS + 1);
   localparam int INDEX_BITS    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int MODE_BITS     = 3;

   localparam logic [MODE_BITS-1:0] MODE_OTHER    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_RELATION = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_BINARY   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_LEFT     = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MIDDLE   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_RIGHT    = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_BEGIN    = 3'd6;

   typedef logic [POSITION_BITS-1:0] position_type;
   typedef logic [COUNT_BITS-1:0]    count_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

`default_nettype wire

// File: rtl/math_delimiter_pair_finder.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_position, req_mode
// rsp       out        rsp_valid/rsp_stall rsp_open_position, rsp_close_position,
//                                          rsp_is_fallback, rsp_last_of_segment
//
// Non-separator tokens do not stall the input. A separator that emits pairs holds
// off input while the pair memory drains, one pair per cycle when the output does
// not stall. A fallback result holds input until it moves to the output register.
// Reset clears all control state; the pair memory needs no clearing.
// A stalled rsp beat holds the output register and backs up the drain.

module math_delimiter_pair_finder (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [mdpf_pkg::POSITION_BITS-1:0] req_position,
   input  wire  [mdpf_pkg::MODE_BITS-1:0]     req_mode,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [mdpf_pkg::POSITION_BITS-1:0] rsp_open_position,
   output logic [mdpf_pkg::POSITION_BITS-1:0] rsp_close_position,
   output logic                         rsp_is_fallback,
   output logic                         rsp_last_of_segment
);

   localparam mdpf_pkg::position_type POS_MAX = {mdpf_pkg::POSITION_BITS{1'b1}};
   localparam mdpf_pkg::count_type    PAIR_LIMIT =
      mdpf_pkg::COUNT_BITS'(mdpf_pkg::MAX_PAIRS);

   mdpf_pkg::state_type    state_ff, state_in;
   mdpf_pkg::position_type segment_start_ff, segment_start_in;
   logic                   opening_seen_ff, opening_seen_in;
   mdpf_pkg::position_type opening_position_ff, opening_position_in;
   logic                   segment_failed_ff, segment_failed_in;
   logic                   small_seen_ff, small_seen_in;
   mdpf_pkg::count_type    pair_count_ff, pair_count_in;
   mdpf_pkg::count_type    read_index_ff, read_index_in;
   logic                   q_valid_ff, q_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [2*mdpf_pkg::POSITION_BITS-1:0] pair_mem [mdpf_pkg::MAX_PAIRS];

   mdpf_pkg::position_type q_open_ff, q_close_ff;
   logic                   q_fallback_ff, q_last_ff;
   mdpf_pkg::position_type out_open_ff, out_close_ff;
   logic                   out_fallback_ff, out_last_ff;

   logic                   accept;
   logic                   move;
   logic                   rd_en;
   logic                   wr_en;
   logic                   fb_load;
   mdpf_pkg::position_type fb_open, fb_close;

   assign req_stall = (state_ff != mdpf_pkg::ST_IDLE) || q_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign move      = q_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign fb_open  = (segment_start_ff == POS_MAX) ? POS_MAX
                                                   : segment_start_ff + 1'b1;
   assign fb_close = (req_position == '0) ? '0 : req_position - 1'b1;

   always_comb begin
      state_in            = state_ff;
      segment_start_in    = segment_start_ff;
      opening_seen_in     = opening_seen_ff;
      opening_position_in = opening_position_ff;
      segment_failed_in   = segment_failed_ff;
      small_seen_in       = small_seen_ff;
      pair_count_in       = pair_count_ff;
      read_index_in       = read_index_ff;
      rd_en               = 1'b0;
      wr_en               = 1'b0;
      fb_load             = 1'b0;

      unique case (state_ff)
         mdpf_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_mode) inside
                  mdpf_pkg::MODE_RELATION, mdpf_pkg::MODE_BINARY: begin
                     pair_count_in = '0;
                     if (small_seen_ff) begin
                        if (segment_failed_ff || opening_seen_ff || pair_count_ff == '0) begin
                           fb_load = 1'b1;
                        end else begin
                           state_in      = mdpf_pkg::ST_DRAIN;
                           read_index_in = '0;
                           pair_count_in = pair_count_ff;
                        end
                     end
                     segment_start_in    = req_position;
                     opening_seen_in     = 1'b0;
                     opening_position_in = '0;
                     segment_failed_in   = 1'b0;
                     small_seen_in       = 1'b0;
                  end
                  mdpf_pkg::MODE_LEFT: begin
                     small_seen_in = 1'b1;
                     if (!segment_failed_ff) begin
                        if (opening_seen_ff) begin
                           segment_failed_in = 1'b1;
                        end else begin
                           opening_seen_in     = 1'b1;
                           opening_position_in = req_position;
                        end
                     end
                  end
                  mdpf_pkg::MODE_MIDDLE: begin
                     small_seen_in = 1'b1;
                     if (!segment_failed_ff && !opening_seen_ff) begin
                        segment_failed_in = 1'b1;
                     end
                  end
                  mdpf_pkg::MODE_RIGHT: begin
                     small_seen_in = 1'b1;
                     if (!segment_failed_ff) begin
                        if (!opening_seen_ff || pair_count_ff >= PAIR_LIMIT) begin
                           segment_failed_in = 1'b1;
                        end else begin
                           wr_en           = 1'b1;
                           pair_count_in   = pair_count_ff + 1'b1;
                           opening_seen_in = 1'b0;
                        end
                     end
                  end
                  mdpf_pkg::MODE_BEGIN: begin
                     segment_start_in    = req_position;
                     opening_seen_in     = 1'b0;
                     opening_position_in = '0;
                     segment_failed_in   = 1'b0;
                     small_seen_in       = 1'b0;
                     pair_count_in       = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mdpf_pkg::ST_DRAIN: begin
            if (read_index_ff != pair_count_ff) begin
               if (!q_valid_ff || move) begin
                  rd_en         = 1'b1;
                  read_index_in = read_index_ff + 1'b1;
               end
            end else if (!q_valid_ff || move) begin
               state_in      = mdpf_pkg::ST_IDLE;
               pair_count_in = '0;
            end
         end
         default: begin
            state_in = mdpf_pkg::ST_IDLE;
         end
      endcase

      q_valid_in = (rd_en || fb_load) ? 1'b1 : (move ? 1'b0 : q_valid_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= mdpf_pkg::ST_IDLE;
         segment_start_ff    <= '0;
         opening_seen_ff     <= 1'b0;
         opening_position_ff <= '0;
         segment_failed_ff   <= 1'b0;
         small_seen_ff       <= 1'b0;
         pair_count_ff       <= '0;
         read_index_ff       <= '0;
         q_valid_ff          <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         segment_start_ff    <= segment_start_in;
         opening_seen_ff     <= opening_seen_in;
         opening_position_ff <= opening_position_in;
         segment_failed_ff   <= segment_failed_in;
         small_seen_ff       <= small_seen_in;
         pair_count_ff       <= pair_count_in;
         read_index_ff       <= read_index_in;
         q_valid_ff          <= q_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // The pair memory is read straight into the staging register behind the output.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[pair_count_ff[mdpf_pkg::INDEX_BITS-1:0]] <=
            {req_position, opening_position_ff};
      end
      if (rd_en) begin
         {q_close_ff, q_open_ff} <= pair_mem[read_index_ff[mdpf_pkg::INDEX_BITS-1:0]];
         q_fallback_ff           <= 1'b0;
         q_last_ff               <= ((read_index_ff + 1'b1) == pair_count_ff);
      end else if (fb_load) begin
         q_open_ff     <= fb_open;
         q_close_ff    <= fb_close;
         q_fallback_ff <= 1'b1;
         q_last_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_open_ff     <= q_open_ff;
         out_close_ff    <= q_close_ff;
         out_fallback_ff <= q_fallback_ff;
         out_last_ff     <= q_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_open_position   = out_open_ff;
   assign rsp_close_position  = out_close_ff;
   assign rsp_is_fallback     = out_fallback_ff;
   assign rsp_last_of_segment = out_last_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [mdpf_pkg::MODE_BITS-1:0] mode_code_type;

   localparam mode_code_type MODE_UNUSED = 3'd7;

   typedef struct packed {
      mdpf_pkg::position_type open_pos;
      mdpf_pkg::position_type close_pos;
      logic                   fallback;
      logic                   last;
   } delim_result_type;

   class delim_scoreboard;
      mdpf_pkg::position_type seg_start    = '0;
      mdpf_pkg::position_type open_pos     = '0;
      bit                     open_pending = 1'b0;
      bit                     seg_broken   = 1'b0;
      bit                     delim_seen   = 1'b0;
      delim_result_type       pair_buf[mdpf_pkg::MAX_PAIRS];
      int                     pair_total   = 0;
      delim_result_type       expected_q[int];
      int                     exp_head     = 0;
      int                     exp_tail     = 0;
      int                     errors       = 0;

      task report(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      function int pending_count();
         return exp_tail - exp_head;
      endfunction

      function void enqueue_expected(input delim_result_type r);
         expected_q[exp_tail] = r;
         exp_tail++;
      endfunction

      function void clear_segment();
         open_pending = 1'b0;
         open_pos     = '0;
         seg_broken   = 1'b0;
         delim_seen   = 1'b0;
         pair_total   = 0;
      endfunction

      function void note_token(input mdpf_pkg::position_type pos, input mode_code_type mode);
         delim_result_type r;
         case (mode)
            mdpf_pkg::MODE_RELATION, mdpf_pkg::MODE_BINARY: begin
               if (delim_seen) begin
                  if (seg_broken || open_pending || pair_total == 0) begin
                     r.open_pos  = (seg_start == '1) ? '1 : seg_start + 1'b1;
                     r.close_pos = (pos == '0) ? '0 : pos - 1'b1;
                     r.fallback  = 1'b1;
                     r.last      = 1'b1;
                     enqueue_expected(r);
                  end else begin
                     for (int i = 0; i < pair_total; i++) begin
                        r      = pair_buf[i];
                        r.last = (i == pair_total - 1);
                        enqueue_expected(r);
                     end
                  end
               end
               seg_start = pos;
               clear_segment();
            end
            mdpf_pkg::MODE_LEFT: begin
               delim_seen = 1'b1;
               if (!seg_broken) begin
                  if (open_pending) begin
                     seg_broken = 1'b1;
                  end else begin
                     open_pending = 1'b1;
                     open_pos     = pos;
                  end
               end
            end
            mdpf_pkg::MODE_MIDDLE: begin
               delim_seen = 1'b1;
               if (!seg_broken && !open_pending) begin
                  seg_broken = 1'b1;
               end
            end
            mdpf_pkg::MODE_RIGHT: begin
               delim_seen = 1'b1;
               if (!seg_broken) begin
                  if (!open_pending || pair_total >= mdpf_pkg::MAX_PAIRS) begin
                     seg_broken = 1'b1;
                  end else begin
                     pair_buf[pair_total].open_pos  = open_pos;
                     pair_buf[pair_total].close_pos = pos;
                     pair_buf[pair_total].fallback  = 1'b0;
                     pair_buf[pair_total].last      = 1'b0;
                     pair_total++;
                     open_pending = 1'b0;
                  end
               end
            end
            mdpf_pkg::MODE_BEGIN: begin
               seg_start = pos;
               clear_segment();
            end
            default: begin
            end
         endcase
      endfunction

      task check_result(input mdpf_pkg::position_type op, input mdpf_pkg::position_type cl,
                        input logic fb, input logic last);
         delim_result_type e;
         if (pending_count() == 0) begin
            report($sformatf("unexpected result open=%0d close=%0d fallback=%0b last=%0b",
                             op, cl, fb, last));
            return;
         end
         e = expected_q[exp_head];
         expected_q.delete(exp_head);
         exp_head++;
         if (op !== e.open_pos)
            report($sformatf("open_position %0d, expected %0d", op, e.open_pos));
         if (cl !== e.close_pos)
            report($sformatf("close_position %0d, expected %0d", cl, e.close_pos));
         if (fb !== e.fallback)
            report($sformatf("is_fallback %0b, expected %0b", fb, e.fallback));
         if (last !== e.last)
            report($sformatf("last_of_segment %0b, expected %0b", last, e.last));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mdpf_pkg::position_type req_position = '0;
   mode_code_type          req_mode = mdpf_pkg::MODE_OTHER;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mdpf_pkg::position_type rsp_open_position;
   mdpf_pkg::position_type rsp_close_position;
   logic                   rsp_is_fallback;
   logic                   rsp_last_of_segment;

   delim_scoreboard sb = new();
   bit              no_idle = 1'b0;
   int              tokens_sent = 0;

   math_delimiter_pair_finder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_position        (req_position),
      .req_mode            (req_mode),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_open_position   (rsp_open_position),
      .rsp_close_position  (rsp_close_position),
      .rsp_is_fallback     (rsp_is_fallback),
      .rsp_last_of_segment (rsp_last_of_segment)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_token(req_position, req_mode);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_open_position, rsp_close_position,
                            rsp_is_fallback, rsp_last_of_segment);
      end
   end

   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic mdpf_pkg::position_type rand_pos();
      return mdpf_pkg::position_type'($urandom());
   endfunction

   task automatic send_token(input mdpf_pkg::position_type pos, input mode_code_type mode);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      req_mode     <= mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens_sent++;
   endtask

   // A tidy segment is a run of left/right pairs, so most separators drain real pairs.
   task automatic send_segment(input int n_pairs, input bit tidy);
      int noise_len;
      if (!tidy) begin
         noise_len = $urandom_range(1, 8);
         for (int i = 0; i < noise_len; i++)
            send_token(rand_pos(), mode_code_type'($urandom_range(0, 7)));
      end else begin
         if ($urandom_range(0, 5) == 0)
            send_token(rand_pos(), mdpf_pkg::MODE_BEGIN);
         for (int i = 0; i < n_pairs; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_token(rand_pos(), mdpf_pkg::MODE_OTHER);
            send_token(rand_pos(), mdpf_pkg::MODE_LEFT);
            if ($urandom_range(0, 3) == 0)
               send_token(rand_pos(), mdpf_pkg::MODE_MIDDLE);
            send_token(rand_pos(), mdpf_pkg::MODE_RIGHT);
         end
         if ($urandom_range(0, 7) == 0)
            send_token(rand_pos(), mdpf_pkg::MODE_LEFT);
      end
      send_token(rand_pos(),
                 $urandom_range(0, 1) ? mdpf_pkg::MODE_RELATION : mdpf_pkg::MODE_BINARY);
   endtask

   initial begin
      int seg_index;
      int n_pairs;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_token(16'hFFFF, mdpf_pkg::MODE_BEGIN);
      send_token(16'd3,    mdpf_pkg::MODE_MIDDLE);
      send_token(16'd0,    mdpf_pkg::MODE_RELATION);
      send_token(16'd1,    mdpf_pkg::MODE_OTHER);
      send_token(16'd2,    MODE_UNUSED);
      send_token(16'd5,    mdpf_pkg::MODE_LEFT);
      send_token(16'd6,    mdpf_pkg::MODE_MIDDLE);
      send_token(16'd7,    mdpf_pkg::MODE_RIGHT);
      send_token(16'd8,    mdpf_pkg::MODE_LEFT);
      send_token(16'd9,    mdpf_pkg::MODE_RIGHT);
      send_token(16'd10,   mdpf_pkg::MODE_BINARY);
      send_token(16'd20,   mdpf_pkg::MODE_RELATION);
      send_token(16'd21,   mdpf_pkg::MODE_RIGHT);
      send_token(16'd22,   mdpf_pkg::MODE_BINARY);
      send_token(16'd23,   mdpf_pkg::MODE_LEFT);
      send_token(16'd24,   mdpf_pkg::MODE_LEFT);
      send_token(16'd25,   mdpf_pkg::MODE_RIGHT);
      send_token(16'd26,   mdpf_pkg::MODE_RELATION);
      send_token(16'd27,   mdpf_pkg::MODE_LEFT);
      send_token(16'd28,   mdpf_pkg::MODE_RELATION);
      send_token(16'd29,   mdpf_pkg::MODE_LEFT);
      send_token(16'd30,   mdpf_pkg::MODE_RIGHT);
      send_token(16'd100,  mdpf_pkg::MODE_BEGIN);
      send_token(16'd101,  mdpf_pkg::MODE_RELATION);

      seg_index = 0;
      while (tokens_sent < 170) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if (seg_index == 0)
            n_pairs = mdpf_pkg::MAX_PAIRS;
         else if (seg_index == 1)
            n_pairs = mdpf_pkg::MAX_PAIRS + 1;
         else if ($urandom_range(0, 19) == 0)
            n_pairs = mdpf_pkg::MAX_PAIRS - 1 + $urandom_range(0, 2);
         else
            n_pairs = $urandom_range(0, 4);
         send_segment(n_pairs, (seg_index < 2) || ($urandom_range(0, 3) != 0));
         seg_index++;
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
